[src/km_pkg.sv]
// Shared types and constants for the k-means clustering engine.
// No dependencies.
package km_pkg;

    localparam int MAX_POINTS   = 1024;
    localparam int MAX_CLUSTERS = 16;
    localparam int MAX_DIMS     = 16;
    localparam int PT_W   = $clog2(MAX_POINTS);
    localparam int CL_W   = $clog2(MAX_CLUSTERS);
    localparam int DM_W   = $clog2(MAX_DIMS);
    localparam int NP_W   = PT_W + 1;
    localparam int NC_W   = CL_W + 1;
    localparam int ND_W   = DM_W + 1;
    localparam int SL_W   = 8;
    localparam int COORD_W = 16;
    localparam int SUM_W  = 28;
    localparam int PROD_W = 32;
    localparam int DIST_W = PROD_W + DM_W;
    localparam int PASS_W = 16;
    localparam int STALE_W = SL_W + 1;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 11;

    typedef enum logic [1:0] {
        KIND_LOAD_POINT  = 2'd0,
        KIND_LOAD_CENTRE = 2'd1,
        KIND_RUN         = 2'd2,
        KIND_QUERY       = 2'd3
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_POINTS   = 2'd0,
        CFG_NUM_CLUSTERS = 2'd1,
        CFG_NUM_DIMS     = 2'd2,
        CFG_STALE_LIMIT  = 2'd3
    } cfg_idx_t;

    typedef enum logic [4:0] {
        S_IDLE, S_QOUT, S_CLR, S_PSTART, S_PTSTART, S_CESTART, S_ELRD, S_ELMUL,
        S_ELACC, S_CEEND, S_PTCHK, S_PEND, S_ZERO, S_MRD, S_ARD, S_AADD,
        S_VC, S_VRD, S_VDIV, S_VWAIT, S_STALE, S_DONE
    } state_t;

    typedef struct packed {
        logic ld_point;
        logic ld_centre;
        logic run_init;
        logic mem_clr_we;
        logic mem_rd_item;
        logic pass_init;
        logic dist_clr;
        logic prod_en;
        logic dist_acc;
        logic best_upd;
        logic mem_chk;
        logic pass_end;
        logic sum_zero_we;
        logic sum_from_mem;
        logic sum_acc_we;
        logic div_start;
        logic cent_we;
        logic early_set;
        logic res_query;
        logic res_run;
        logic [PT_W-1:0] pidx;
        logic [CL_W-1:0] cidx;
        logic [DM_W-1:0] didx;
        logic [PT_W-1:0] sweep;
        logic [NP_W-1:0] npts;
        logic [SL_W-1:0] slimit;
    } km_cmd_t;

    typedef struct packed {
        logic changes_zero;
        logic stale_over;
        logic count_zero;
        logic div_done;
    } km_stat_t;

endpackage

[src/km_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module km_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

[src/km_div.sv]
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// Depends on km_pkg.
module km_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [km_pkg::SUM_W-1:0]     dividend,
    input  logic [km_pkg::NP_W-1:0]             divisor,
    output logic signed [km_pkg::COORD_W-1:0]   quotient,
    output logic                                done
);

    localparam int CNT_W = $clog2(km_pkg::SUM_W + 1);

    logic [km_pkg::SUM_W-1:0] a_reg, a_next;
    logic [km_pkg::NP_W-1:0]  rem_reg, rem_next;
    logic [km_pkg::NP_W-1:0]  den_reg, den_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     neg_reg, neg_next;
    logic                     run_reg, run_next;
    logic                     done_reg, done_next;
    logic [km_pkg::NP_W:0]    trial;
    logic                     ge;
    logic [km_pkg::SUM_W-1:0] qfull;

    assign trial = {rem_reg, a_reg[km_pkg::SUM_W-1]};
    assign ge    = trial >= {1'b0, den_reg};

    always_comb
    begin
        a_next    = a_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            neg_next = dividend[km_pkg::SUM_W-1];
            a_next   = dividend[km_pkg::SUM_W-1] ? (~dividend + 1'b1) : dividend;
            rem_next = '0;
            den_next = divisor;
            cnt_next = CNT_W'(km_pkg::SUM_W);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            rem_next = ge ? km_pkg::NP_W'(trial - {1'b0, den_reg})
                          : trial[km_pkg::NP_W-1:0];
            a_next   = {a_reg[km_pkg::SUM_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign qfull    = neg_reg ? (~a_reg + 1'b1) : a_reg;
    assign quotient = qfull[km_pkg::COORD_W-1:0];
    assign done     = done_reg;

endmodule

[src/km_dpath.sv]
// Datapath: point, centre, membership and sum stores, distance and divider.
// Depends on km_pkg, km_ram, km_div.
module km_dpath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  km_pkg::km_cmd_t                    cmd,
    output km_pkg::km_stat_t                   stat,
    input  logic [km_pkg::PT_W-1:0]            item_index,
    input  logic [km_pkg::DM_W-1:0]            dim_index,
    input  logic signed [km_pkg::COORD_W-1:0]  coord_value,
    output logic [km_pkg::NC_W-1:0]            cluster_index,
    output logic [km_pkg::PASS_W-1:0]          pass_count,
    output logic                               stopped_early
);

    localparam int PS_AW = km_pkg::PT_W + km_pkg::DM_W;
    localparam int CS_AW = km_pkg::CL_W + km_pkg::DM_W;

    logic signed [km_pkg::COORD_W-1:0] pt_q, ce_q, div_q;
    logic [km_pkg::NC_W-1:0]           mem_q;
    logic signed [km_pkg::SUM_W-1:0]   sum_q;
    logic signed [km_pkg::COORD_W:0]   diff;
    logic signed [2*km_pkg::COORD_W+1:0] sq;
    logic [km_pkg::PROD_W-1:0]         prod_reg;
    logic [km_pkg::DIST_W-1:0]         dist_reg, best_reg;
    logic [km_pkg::CL_W-1:0]           bidx_reg;
    logic [km_pkg::NP_W-1:0]           counts_reg [km_pkg::MAX_CLUSTERS];
    logic [km_pkg::NP_W-1:0]           changes_reg, least_reg;
    logic [km_pkg::STALE_W-1:0]        stale_reg;
    logic [km_pkg::PASS_W-1:0]         passes_reg;
    logic                              early_reg, seen_reg;
    logic                              mismatch;
    logic                              mem_we, cent_we;
    logic [km_pkg::PT_W-1:0]           mem_waddr, mem_raddr;
    logic [km_pkg::NC_W-1:0]           mem_wdata;
    logic                              sum_we;
    logic [CS_AW-1:0]                  sum_waddr, sum_raddr, cent_waddr;
    logic [km_pkg::SUM_W-1:0]          sum_wdata;
    logic [km_pkg::COORD_W-1:0]        cent_wdata;

    km_ram #(.WIDTH(km_pkg::COORD_W), .DEPTH(km_pkg::MAX_POINTS * km_pkg::MAX_DIMS)) u_pts (
        .clk   (clk),
        .we    (cmd.ld_point),
        .waddr ({item_index, dim_index}),
        .wdata (coord_value),
        .raddr (PS_AW'({cmd.pidx, cmd.didx})),
        .rdata (pt_q)
    );

    assign cent_we    = cmd.cent_we
                      | (cmd.ld_centre && (item_index < km_pkg::PT_W'(km_pkg::MAX_CLUSTERS)));
    assign cent_waddr = cmd.cent_we ? {cmd.cidx, cmd.didx}
                                    : {item_index[km_pkg::CL_W-1:0], dim_index};
    assign cent_wdata = cmd.cent_we ? div_q : coord_value;

    km_ram #(.WIDTH(km_pkg::COORD_W), .DEPTH(km_pkg::MAX_CLUSTERS * km_pkg::MAX_DIMS)) u_cen (
        .clk   (clk),
        .we    (cent_we),
        .waddr (cent_waddr),
        .wdata (cent_wdata),
        .raddr ({cmd.cidx, cmd.didx}),
        .rdata (ce_q)
    );

    assign mismatch  = mem_q != {1'b0, bidx_reg};
    assign mem_we    = cmd.mem_clr_we | (cmd.mem_chk & mismatch);
    assign mem_waddr = cmd.mem_clr_we ? cmd.sweep : cmd.pidx;
    assign mem_wdata = cmd.mem_clr_we ? km_pkg::NC_W'(km_pkg::MAX_CLUSTERS) : {1'b0, bidx_reg};
    assign mem_raddr = cmd.mem_rd_item ? item_index : cmd.pidx;

    km_ram #(.WIDTH(km_pkg::NC_W), .DEPTH(km_pkg::MAX_POINTS)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_q)
    );

    assign sum_we    = cmd.sum_zero_we | cmd.sum_acc_we;
    assign sum_waddr = cmd.sum_zero_we ? cmd.sweep[CS_AW-1:0]
                                       : {mem_q[km_pkg::CL_W-1:0], cmd.didx};
    assign sum_wdata = cmd.sum_zero_we ? '0
                     : km_pkg::SUM_W'(sum_q + km_pkg::SUM_W'(pt_q));
    assign sum_raddr = cmd.sum_from_mem ? {mem_q[km_pkg::CL_W-1:0], cmd.didx}
                                        : {cmd.cidx, cmd.didx};

    km_ram #(.WIDTH(km_pkg::SUM_W), .DEPTH(km_pkg::MAX_CLUSTERS * km_pkg::MAX_DIMS)) u_sum (
        .clk   (clk),
        .we    (sum_we),
        .waddr (sum_waddr),
        .wdata (sum_wdata),
        .raddr (sum_raddr),
        .rdata (sum_q)
    );

    km_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (sum_q),
        .divisor  (counts_reg[cmd.cidx]),
        .quotient (div_q),
        .done     (stat.div_done)
    );

    assign diff = {pt_q[km_pkg::COORD_W-1], pt_q} - {ce_q[km_pkg::COORD_W-1], ce_q};
    assign sq   = diff * diff;

    always_ff @(posedge clk)
    begin
        if (cmd.prod_en)
        begin
            prod_reg <= sq[km_pkg::PROD_W-1:0];
        end
        if (cmd.dist_clr)
        begin
            dist_reg <= '0;
        end
        else if (cmd.dist_acc)
        begin
            dist_reg <= dist_reg + km_pkg::DIST_W'(prod_reg);
        end
        if (cmd.best_upd && ((cmd.cidx == '0) || (dist_reg < best_reg)))
        begin
            best_reg <= dist_reg;
            bidx_reg <= cmd.cidx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < km_pkg::MAX_CLUSTERS; i++)
            begin
                counts_reg[i] <= '0;
            end
            changes_reg <= '0;
            least_reg   <= km_pkg::NP_W'(1);
            stale_reg   <= '0;
            passes_reg  <= '0;
            early_reg   <= 1'b0;
            seen_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.run_init)
            begin
                least_reg  <= cmd.npts;
                stale_reg  <= '0;
                passes_reg <= '0;
                early_reg  <= 1'b0;
                seen_reg   <= 1'b1;
            end
            if (cmd.pass_init)
            begin
                for (int i = 0; i < km_pkg::MAX_CLUSTERS; i++)
                begin
                    counts_reg[i] <= '0;
                end
                changes_reg <= '0;
            end
            if (cmd.mem_chk)
            begin
                counts_reg[bidx_reg] <= counts_reg[bidx_reg] + 1'b1;
                if (mismatch)
                begin
                    changes_reg <= changes_reg + 1'b1;
                end
            end
            if (cmd.pass_end)
            begin
                if (changes_reg < least_reg)
                begin
                    least_reg <= changes_reg;
                    stale_reg <= '0;
                end
                else if (stale_reg < km_pkg::STALE_W'(256))
                begin
                    stale_reg <= stale_reg + 1'b1;
                end
                if (passes_reg != '1)
                begin
                    passes_reg <= passes_reg + 1'b1;
                end
            end
            if (cmd.early_set)
            begin
                early_reg <= 1'b1;
            end
        end
    end

    assign stat.changes_zero = changes_reg == '0;
    assign stat.stale_over   = stale_reg > {1'b0, cmd.slimit};
    assign stat.count_zero   = counts_reg[cmd.cidx] == '0;

    assign cluster_index = !cmd.res_query ? '0
                         : (seen_reg ? mem_q : km_pkg::NC_W'(km_pkg::MAX_CLUSTERS));
    assign pass_count    = cmd.res_run ? passes_reg : '0;
    assign stopped_early = cmd.res_run & early_reg;

endmodule

[src/km_ctrl.sv]
// Controller: configuration registers, sequencing state machine, loop counters.
// Depends on km_pkg.
module km_ctrl (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [1:0]                       kind,
    output logic                             busy,
    output logic                             done,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [km_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [km_pkg::CFG_DATA_W-1:0]    cfg_data,
    output km_pkg::km_cmd_t                  cmd,
    input  km_pkg::km_stat_t                 stat
);

    km_pkg::state_t state_reg, state_next;

    logic [km_pkg::NP_W-1:0] np_reg;
    logic [km_pkg::NC_W-1:0] nc_reg;
    logic [km_pkg::ND_W-1:0] nd_reg;
    logic [km_pkg::SL_W-1:0] sl_reg;

    logic [km_pkg::PT_W-1:0] p_reg, p_next;
    logic [km_pkg::CL_W-1:0] c_reg, c_next;
    logic [km_pkg::DM_W-1:0] j_reg, j_next;
    logic [km_pkg::PT_W-1:0] i_reg, i_next;

    logic [km_pkg::NP_W-1:0] n_eff;
    logic [km_pkg::NC_W-1:0] kc, k_eff;
    logic [km_pkg::ND_W-1:0] d_eff;
    logic                    p_last, c_last, j_last, accept;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            np_reg <= km_pkg::NP_W'(1);
            nc_reg <= km_pkg::NC_W'(16);
            nd_reg <= km_pkg::ND_W'(16);
            sl_reg <= km_pkg::SL_W'(50);
        end
        else if (cfg_valid)
        begin
            unique case (km_pkg::cfg_idx_t'(cfg_index))
                km_pkg::CFG_NUM_POINTS:   np_reg <= cfg_data[km_pkg::NP_W-1:0];
                km_pkg::CFG_NUM_CLUSTERS: nc_reg <= cfg_data[km_pkg::NC_W-1:0];
                km_pkg::CFG_NUM_DIMS:     nd_reg <= cfg_data[km_pkg::ND_W-1:0];
                km_pkg::CFG_STALE_LIMIT:  sl_reg <= cfg_data[km_pkg::SL_W-1:0];
                default:                  ;
            endcase
        end
    end

    assign n_eff = (np_reg == '0) ? km_pkg::NP_W'(1)
                 : (np_reg > km_pkg::NP_W'(km_pkg::MAX_POINTS))
                   ? km_pkg::NP_W'(km_pkg::MAX_POINTS) : np_reg;
    assign kc    = (nc_reg == '0) ? km_pkg::NC_W'(1)
                 : (nc_reg > km_pkg::NC_W'(km_pkg::MAX_CLUSTERS))
                   ? km_pkg::NC_W'(km_pkg::MAX_CLUSTERS) : nc_reg;
    assign k_eff = (km_pkg::NP_W'(kc) > n_eff) ? n_eff[km_pkg::NC_W-1:0] : kc;
    assign d_eff = (nd_reg == '0) ? km_pkg::ND_W'(1)
                 : (nd_reg > km_pkg::ND_W'(km_pkg::MAX_DIMS))
                   ? km_pkg::ND_W'(km_pkg::MAX_DIMS) : nd_reg;

    assign p_last = {1'b0, p_reg} == (n_eff - 1'b1);
    assign c_last = {1'b0, c_reg} == (k_eff - 1'b1);
    assign j_last = {1'b0, j_reg} == (d_eff - 1'b1);
    assign accept = start && (state_reg == km_pkg::S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            km_pkg::S_IDLE:
            begin
                if (start)
                begin
                    unique case (km_pkg::kind_t'(kind))
                        km_pkg::KIND_QUERY: state_next = km_pkg::S_QOUT;
                        km_pkg::KIND_RUN:   state_next = km_pkg::S_CLR;
                        default:            state_next = km_pkg::S_IDLE;
                    endcase
                end
            end
            km_pkg::S_QOUT:    state_next = km_pkg::S_IDLE;
            km_pkg::S_CLR:     state_next = (i_reg == '1) ? km_pkg::S_PSTART : km_pkg::S_CLR;
            km_pkg::S_PSTART:  state_next = km_pkg::S_PTSTART;
            km_pkg::S_PTSTART: state_next = km_pkg::S_CESTART;
            km_pkg::S_CESTART: state_next = km_pkg::S_ELRD;
            km_pkg::S_ELRD:    state_next = km_pkg::S_ELMUL;
            km_pkg::S_ELMUL:   state_next = km_pkg::S_ELACC;
            km_pkg::S_ELACC:   state_next = j_last ? km_pkg::S_CEEND : km_pkg::S_ELRD;
            km_pkg::S_CEEND:   state_next = c_last ? km_pkg::S_PTCHK : km_pkg::S_CESTART;
            km_pkg::S_PTCHK:   state_next = p_last ? km_pkg::S_PEND : km_pkg::S_PTSTART;
            km_pkg::S_PEND:    state_next = stat.changes_zero ? km_pkg::S_DONE : km_pkg::S_ZERO;
            km_pkg::S_ZERO:
                state_next = (i_reg[km_pkg::CL_W+km_pkg::DM_W-1:0] == '1)
                             ? km_pkg::S_MRD : km_pkg::S_ZERO;
            km_pkg::S_MRD:     state_next = km_pkg::S_ARD;
            km_pkg::S_ARD:     state_next = km_pkg::S_AADD;
            km_pkg::S_AADD:
                state_next = !j_last ? km_pkg::S_ARD
                           : (p_last ? km_pkg::S_VC : km_pkg::S_MRD);
            km_pkg::S_VC:
                state_next = !stat.count_zero ? km_pkg::S_VRD
                           : (c_last ? km_pkg::S_STALE : km_pkg::S_VC);
            km_pkg::S_VRD:     state_next = km_pkg::S_VDIV;
            km_pkg::S_VDIV:    state_next = km_pkg::S_VWAIT;
            km_pkg::S_VWAIT:
            begin
                if (stat.div_done)
                begin
                    state_next = !j_last ? km_pkg::S_VRD
                               : (c_last ? km_pkg::S_STALE : km_pkg::S_VC);
                end
            end
            km_pkg::S_STALE:   state_next = stat.stale_over ? km_pkg::S_DONE : km_pkg::S_PSTART;
            km_pkg::S_DONE:    state_next = km_pkg::S_IDLE;
            default:           state_next = km_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        p_next = p_reg;
        c_next = c_reg;
        j_next = j_reg;
        i_next = i_reg;
        case (state_reg)
            km_pkg::S_IDLE:    i_next = '0;
            km_pkg::S_CLR:     i_next = i_reg + 1'b1;
            km_pkg::S_PSTART:  p_next = '0;
            km_pkg::S_PTSTART: c_next = '0;
            km_pkg::S_CESTART: j_next = '0;
            km_pkg::S_ELACC:   j_next = j_reg + 1'b1;
            km_pkg::S_CEEND:   c_next = c_reg + 1'b1;
            km_pkg::S_PTCHK:   p_next = p_reg + 1'b1;
            km_pkg::S_PEND:    i_next = '0;
            km_pkg::S_ZERO:
            begin
                i_next = i_reg + 1'b1;
                p_next = '0;
            end
            km_pkg::S_MRD:     j_next = '0;
            km_pkg::S_AADD:
            begin
                j_next = j_reg + 1'b1;
                if (j_last)
                begin
                    p_next = p_reg + 1'b1;
                    c_next = '0;
                end
            end
            km_pkg::S_VC:
            begin
                j_next = '0;
                if (stat.count_zero)
                begin
                    c_next = c_reg + 1'b1;
                end
            end
            km_pkg::S_VWAIT:
            begin
                if (stat.div_done)
                begin
                    j_next = j_reg + 1'b1;
                    if (j_last)
                    begin
                        c_next = c_reg + 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= km_pkg::S_IDLE;
            p_reg     <= '0;
            c_reg     <= '0;
            j_reg     <= '0;
            i_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            p_reg     <= p_next;
            c_reg     <= c_next;
            j_reg     <= j_next;
            i_reg     <= i_next;
        end
    end

    always_comb
    begin
        cmd              = '0;
        cmd.pidx         = p_reg;
        cmd.cidx         = c_reg;
        cmd.didx         = j_reg;
        cmd.sweep        = i_reg;
        cmd.npts         = n_eff;
        cmd.slimit       = sl_reg;
        busy             = 1'b1;
        done             = 1'b0;
        unique case (state_reg)
            km_pkg::S_IDLE:
            begin
                busy            = 1'b0;
                cmd.mem_rd_item = 1'b1;
                cmd.ld_point    = accept && (km_pkg::kind_t'(kind) == km_pkg::KIND_LOAD_POINT);
                cmd.ld_centre   = accept && (km_pkg::kind_t'(kind) == km_pkg::KIND_LOAD_CENTRE);
                cmd.run_init    = accept && (km_pkg::kind_t'(kind) == km_pkg::KIND_RUN);
            end
            km_pkg::S_QOUT:
            begin
                done          = 1'b1;
                cmd.res_query = 1'b1;
            end
            km_pkg::S_CLR:     cmd.mem_clr_we = 1'b1;
            km_pkg::S_PSTART:  cmd.pass_init = 1'b1;
            km_pkg::S_CESTART: cmd.dist_clr = 1'b1;
            km_pkg::S_ELMUL:   cmd.prod_en = 1'b1;
            km_pkg::S_ELACC:   cmd.dist_acc = 1'b1;
            km_pkg::S_CEEND:   cmd.best_upd = 1'b1;
            km_pkg::S_PTCHK:   cmd.mem_chk = 1'b1;
            km_pkg::S_PEND:    cmd.pass_end = 1'b1;
            km_pkg::S_ZERO:    cmd.sum_zero_we = 1'b1;
            km_pkg::S_MRD:     cmd.sum_from_mem = 1'b1;
            km_pkg::S_ARD:     cmd.sum_from_mem = 1'b1;
            km_pkg::S_AADD:
            begin
                cmd.sum_from_mem = 1'b1;
                cmd.sum_acc_we   = 1'b1;
            end
            km_pkg::S_VDIV:    cmd.div_start = 1'b1;
            km_pkg::S_VWAIT:   cmd.cent_we = stat.div_done;
            km_pkg::S_STALE:   cmd.early_set = stat.stale_over;
            km_pkg::S_DONE:
            begin
                done        = 1'b1;
                cmd.res_run = 1'b1;
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n) done |-> busy)
        else $error("result strobe while idle");
    a_query_next: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (kind == km_pkg::KIND_QUERY)) |=> (done && cmd.res_query))
        else $error("query result not in next cycle");
    a_cent_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cent_we |-> stat.div_done)
        else $error("centre write without quotient");
    a_pass_changes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == km_pkg::S_PEND && stat.changes_zero) |=> cmd.res_run)
        else $error("converged pass did not finish run");
`endif

endmodule

[src/kmeans_cluster_engine_unit.sv]
// Top level of the k-means clustering engine.
// Depends on km_pkg, km_ctrl, km_dpath.
//
// Loads of point and centre coordinates produce no result; busy stays low so
// one can be issued every cycle. A query answers on done in the cycle after
// it is accepted. A run first clears the 1024-entry membership store, then
// each pass runs assignment and, unless no point changed cluster, zeroing of
// sums, accumulation and division (on the shared serial divider), all bound
// by single-port store reads. done is a one-cycle strobe; the receiver cannot
// stall it, so results must be taken when shown.
module kmeans_cluster_engine_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         kind,
    input  logic [km_pkg::PT_W-1:0]            item_index,
    input  logic [km_pkg::DM_W-1:0]            dim_index,
    input  logic signed [km_pkg::COORD_W-1:0]  coord_value,
    output logic                               done,
    output logic [km_pkg::NC_W-1:0]            cluster_index,
    output logic [km_pkg::PASS_W-1:0]          pass_count,
    output logic                               stopped_early,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [km_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [km_pkg::CFG_DATA_W-1:0]      cfg_data
);

    km_pkg::km_cmd_t  cmd;
    km_pkg::km_stat_t stat;

    km_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .kind      (kind),
        .busy      (busy),
        .done      (done),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat)
    );

    km_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .item_index    (item_index),
        .dim_index     (dim_index),
        .coord_value   (coord_value),
        .cluster_index (cluster_index),
        .pass_count    (pass_count),
        .stopped_early (stopped_early)
    );

endmodule
